>>> hdl/cxpc_pkg.sv
// shared types, constants and helpers for the chained xor packet cipher
// no dependencies; imported by cxpc_lane and the top level
package cxpc_pkg;

   localparam int KEY_W  = 32;
   localparam int BYTE_W = 8;
   localparam int ADDR_W = 3;

   localparam int unsigned MAX_PACKET_BYTES_DEF = 65536;

   localparam logic [KEY_W-1:0] HIGH_BIT_LIMIT = 32'h8000_0000;
   localparam logic [KEY_W-1:0] ALL_ONES       = 32'hFFFF_FFFF;

   // register index codes (address bit 2)
   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   // direction codes
   localparam logic OP_DECODE = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   typedef struct packed {
      logic step;   // one byte is consumed this cycle
      logic last;   // that byte closes the packet
      logic load;   // reload key, clear chain and position
   } lane_ctrl_type;

   // high word is forced to all ones once the low word has its top bit set
   function automatic logic [KEY_W-1:0] forced_high(input logic [KEY_W-1:0] low,
                                                    input logic [KEY_W-1:0] high);
      forced_high = (low >= HIGH_BIT_LIMIT) ? ALL_ONES : high;
   endfunction

endpackage

>>> hdl/cxpc_lane.sv
// key, chaining byte and position state for one direction, plus its byte transform
// depends on cxpc_pkg
module cxpc_lane #(
   parameter int unsigned MAX_PACKET_BYTES = cxpc_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cxpc_pkg::lane_ctrl_type       ctrl,
   input  logic [cxpc_pkg::KEY_W-1:0]    load_low,
   input  logic [cxpc_pkg::KEY_W-1:0]    load_high,
   input  logic                          chain_from_out,
   input  logic [cxpc_pkg::BYTE_W-1:0]   data_in,
   output logic [cxpc_pkg::BYTE_W-1:0]   data_out
);
   import cxpc_pkg::*;

   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

   logic [KEY_W-1:0]  key_low_ff, key_low_in;
   logic [KEY_W-1:0]  key_high_ff, key_high_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   logic              active;
   logic [POS_W-1:0]  pos_inc;
   logic [KEY_W-1:0]  pos_ext;
   logic [KEY_W-1:0]  len_ext;
   logic [KEY_W-1:0]  low_sum;
   logic [2:0]        key_idx;
   logic [2*KEY_W-1:0] key_all;
   logic [BYTE_W-1:0] key_byte;

   assign active  = (key_low_ff | key_high_ff) != '0;
   assign pos_ext = KEY_W'(pos_ff);
   assign key_idx = pos_ext[2:0];
   assign key_all = {key_high_ff, key_low_ff};
   assign key_byte = key_all[key_idx*BYTE_W +: BYTE_W];

   // position saturates at the packet bound
   assign pos_inc = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
   assign len_ext = KEY_W'(pos_inc);
   assign low_sum = key_low_ff + len_ext;

   always_comb begin
      data_out = data_in;
      if (active) begin
         data_out = data_in ^ key_byte;
         if (pos_ff != '0) begin
            data_out = data_out ^ prev_ff;
         end
      end
   end

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      prev_in     = prev_ff;
      pos_in      = pos_ff;
      priority if (ctrl.load) begin
         key_low_in  = load_low;
         key_high_in = forced_high(load_low, load_high);
         prev_in     = '0;
         pos_in      = '0;
      end else if (ctrl.step) begin
         if (active) begin
            prev_in = chain_from_out ? data_out : data_in;
         end
         if (ctrl.last) begin
            pos_in = '0;
            if (active) begin
               key_low_in  = low_sum;
               key_high_in = forced_high(low_sum, key_high_ff);
            end
         end else begin
            pos_in = pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         prev_ff     <= '0;
         pos_ff      <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         prev_ff     <= prev_in;
         pos_ff      <= pos_in;
      end
   end

endmodule

>>> hdl/chained_xor_packet_cipher_unit.sv
// top level of the chained xor packet cipher: csr port, input and result registers
// depends on cxpc_pkg and cxpc_lane
//
// usage:
//   req channel (req_valid/req_ready) carries one packet byte per transaction with its
//   direction (req_operation: 1 encode, 0 decode) and last-byte mark (req_packet_end).
//   rsp channel (rsp_valid/rsp_ready) returns the transformed byte and the copied mark,
//   one result per request, in order.
//   rsp_valid rises once the accepted byte has passed through both registers: it sits in
//   the input register, and the direction's lane transforms it and updates its state as
//   it moves to the result register, which drives the rsp channel.
//   throughput is one byte per cycle while rsp_ready is high; the key/chain/position
//   update in each lane sets that figure, and a byte may follow either direction freely.
//   when rsp_ready is low the result register holds and the input register still takes
//   one more byte; req_ready drops once both are full.
//   the apb port holds the two initial key words at byte addresses 0 and 4; a write to
//   either reloads both directions' keys and clears their chaining and position.
//   synchronous reset empties both registers and sets all key state to zero, which
//   makes the block pass bytes through until a nonzero key is written.
module chained_xor_packet_cipher_unit #(
   parameter int unsigned MAX_PACKET_BYTES = cxpc_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [cxpc_pkg::BYTE_W-1:0]   req_data_in,
   input  logic                          req_packet_end,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cxpc_pkg::BYTE_W-1:0]   rsp_data_out,
   output logic                          rsp_end_out,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cxpc_pkg::ADDR_W-1:0]   paddr,
   input  logic [cxpc_pkg::KEY_W-1:0]    pwdata,
   output logic [cxpc_pkg::KEY_W-1:0]    prdata,
   output logic                          pready
);
   import cxpc_pkg::*;

   logic [KEY_W-1:0] init_low_ff, init_low_in;
   logic [KEY_W-1:0] init_high_ff, init_high_in;
   logic             csr_write;
   logic             reg_idx;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_op_ff;
   logic [BYTE_W-1:0] s1_data_ff;
   logic              s1_end_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff;
   logic              out_end_ff;

   logic              advance;
   logic              req_take;
   lane_ctrl_type     enc_ctrl, dec_ctrl;
   logic [BYTE_W-1:0] enc_data, dec_data;

   // csr access
   assign pready    = 1'b1;
   assign reg_idx   = paddr[2];
   assign csr_write = psel & penable & pwrite & pready;
   assign prdata    = (reg_idx == REG_KEY_HIGH) ? init_high_ff : init_low_ff;

   always_comb begin
      init_low_in  = init_low_ff;
      init_high_in = init_high_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_KEY_LOW: begin
               init_low_in = pwdata;
            end
            REG_KEY_HIGH: begin
               init_high_in = pwdata;
            end
            default: begin
               init_low_in = init_low_ff;
            end
         endcase
      end
   end

   // handshake: result register can take the staged byte when empty or draining
   assign advance   = s1_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   assign s1_valid_in  = req_take | (s1_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   always_comb begin
      enc_ctrl.step = advance & (s1_op_ff == OP_ENCODE);
      enc_ctrl.last = s1_end_ff;
      enc_ctrl.load = csr_write;
      dec_ctrl.step = advance & (s1_op_ff == OP_DECODE);
      dec_ctrl.last = s1_end_ff;
      dec_ctrl.load = csr_write;
   end

   cxpc_lane #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_enc_lane (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (enc_ctrl),
      .load_low       (init_low_in),
      .load_high      (init_high_in),
      .chain_from_out (1'b1),
      .data_in        (s1_data_ff),
      .data_out       (enc_data)
   );

   cxpc_lane #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_dec_lane (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (dec_ctrl),
      .load_low       (init_low_in),
      .load_high      (init_high_in),
      .chain_from_out (1'b0),
      .data_in        (s1_data_ff),
      .data_out       (dec_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         init_low_ff  <= '0;
         init_high_ff <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         init_low_ff  <= init_low_in;
         init_high_ff <= init_high_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_operation;
         s1_data_ff <= req_data_in;
         s1_end_ff  <= req_packet_end;
      end
      if (advance) begin
         out_data_ff <= (s1_op_ff == OP_ENCODE) ? enc_data : dec_data;
         out_end_ff  <= s1_end_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = out_data_ff;
   assign rsp_end_out  = out_end_ff;

endmodule
